// ===== rtl/ssga_pkg.sv =====
// Shared types and constants of the sparse scatter-accumulate engine.
`timescale 1ns / 1ps

package ssga_pkg;

	localparam int GRID_POINTS_DEF = 4096;

	localparam int IDX_W     = 12;
	localparam int WORD_W    = 32;
	localparam int NUM_WORDS = 4;
	localparam int ACC_W     = 40;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int FRAC_W    = 16;
	localparam int DELTA_W   = SUM_W - FRAC_W;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		op_t                        op;
		logic [IDX_W-1:0]           src;
		logic [IDX_W-1:0]           tgt;
		logic                       read_ok;
		logic [NUM_WORDS*WORD_W-1:0] words;
	} item_t;

endpackage

// ===== rtl/ssga_front.sv =====
// Front end: takes requests, range-checks them and drops loads and accumulates outside the grid.
`timescale 1ns / 1ps

module ssga_front #(
	parameter int GRID_POINTS = ssga_pkg::GRID_POINTS_DEF
) (
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      req_type,
	input  logic [ssga_pkg::IDX_W-1:0]      source_index,
	input  logic [ssga_pkg::IDX_W-1:0]      target_index,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_0,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_1,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_2,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_3,
	input  logic                            q_full,
	input  logic                            init_busy,
	output logic                            push,
	output ssga_pkg::item_t                 push_item
);

	logic          src_ok;
	logic          tgt_ok;
	logic          keep;
	ssga_pkg::op_t op;

	assign op     = ssga_pkg::op_t'(req_type);
	assign src_ok = 32'(source_index) < 32'(GRID_POINTS);
	assign tgt_ok = 32'(target_index) < 32'(GRID_POINTS);
	assign busy   = q_full | init_busy;

	always_comb begin
		case (op)
			ssga_pkg::OP_LOAD:  keep = src_ok;
			ssga_pkg::OP_ACC:   keep = src_ok & tgt_ok;
			ssga_pkg::OP_READ:  keep = 1'b1;
			ssga_pkg::OP_CLEAR: keep = 1'b1;
			default:            keep = 1'b0;
		endcase
	end

	// Drop loads and accumulates that point outside the grid.
	assign push = start & ~busy & keep;

	assign push_item.op      = op;
	assign push_item.src     = source_index;
	assign push_item.tgt     = target_index;
	assign push_item.read_ok = tgt_ok;
	assign push_item.words   = {word_3, word_2, word_1, word_0};

endmodule

// ===== rtl/ssga_queue.sv =====
// Short request queue between front end and execution back end.
`timescale 1ns / 1ps

module ssga_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ssga_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ssga_pkg::item_t head_item
);

	ssga_pkg::item_t                mem_q [ssga_pkg::QUEUE_DEPTH];
	logic [ssga_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [ssga_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [ssga_pkg::QPTR_W:0]     count_q;

	assign full       = count_q == (ssga_pkg::QPTR_W + 1)'(ssga_pkg::QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == ssga_pkg::QPTR_W'(ssga_pkg::QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == ssga_pkg::QPTR_W'(ssga_pkg::QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ssga_mac.sv =====
// Three-stage 4-term dot product with round-half-up reduction to Q.16.
`timescale 1ns / 1ps

module ssga_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ssga_pkg::NUM_WORDS*ssga_pkg::WORD_W-1:0] weights,
	input  logic [ssga_pkg::NUM_WORDS*ssga_pkg::WORD_W-1:0] coefs,
	output logic                               delta_valid,
	output logic signed [ssga_pkg::DELTA_W-1:0] delta
);

	localparam int WW = ssga_pkg::WORD_W;
	localparam int PW = ssga_pkg::PROD_W;
	localparam int SW = ssga_pkg::SUM_W;

	logic signed [PW-1:0] prod_s1 [ssga_pkg::NUM_WORDS];
	logic signed [PW:0]   sum01_s2;
	logic signed [PW:0]   sum23_s2;
	logic signed [SW-1:0] total;
	logic signed [ssga_pkg::DELTA_W-1:0] delta_s3;
	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;

	// One 32x32 product per lane.
	always_ff @(posedge clk) begin
		for (int k = 0; k < ssga_pkg::NUM_WORDS; k++) begin
			prod_s1[k] <= $signed(weights[k*WW +: WW]) * $signed(coefs[k*WW +: WW]);
		end
		sum01_s2 <= (PW + 1)'(prod_s1[0]) + (PW + 1)'(prod_s1[1]);
		sum23_s2 <= (PW + 1)'(prod_s1[2]) + (PW + 1)'(prod_s1[3]);
		delta_s3 <= total[SW-1:ssga_pkg::FRAC_W];
	end

	// Exact sum plus one half LSB, then floor by dropping the fraction.
	assign total = SW'(sum01_s2) + SW'(sum23_s2) + SW'(33'sd32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign delta_valid = v_s3;
	assign delta       = delta_s3;

endmodule

// ===== rtl/ssga_back.sv =====
// Back end: coefficient and result memories, sequencer, saturating update.
`timescale 1ns / 1ps

module ssga_back #(
	parameter int GRID_POINTS = ssga_pkg::GRID_POINTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             head_valid,
	input  ssga_pkg::item_t                  head_item,
	output logic                             pop,
	output logic                             init_busy,
	output logic                             done,
	output logic signed [ssga_pkg::ACC_W-1:0] read_value,
	output logic                             saturated_flag
);

	localparam int ADDR_W = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
	localparam int EXT_W  = ADDR_W + ssga_pkg::IDX_W;
	localparam int AW     = ssga_pkg::ACC_W;
	localparam int UPD_W  = ssga_pkg::DELTA_W + 1;
	localparam int CW     = ssga_pkg::NUM_WORDS * ssga_pkg::WORD_W;

	localparam logic signed [UPD_W-1:0] ACC_HI = {{(UPD_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
	localparam logic signed [UPD_W-1:0] ACC_LO = {{(UPD_W-AW+1){1'b1}}, {(AW-1){1'b0}}};

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_CLEAR = 6'b000100,
		ST_READ  = 6'b001000,
		ST_MUL   = 6'b010000,
		ST_WAIT  = 6'b100000
	} state_t;

	logic [CW-1:0] coef_mem [GRID_POINTS];
	logic [AW:0]   res_mem  [GRID_POINTS];

	state_t          state_q;
	logic [ADDR_W-1:0] cnt_q;
	ssga_pkg::item_t cur_q;
	logic [CW-1:0]   coef_rd_q;
	logic [AW:0]     res_rd_q;
	logic            done_q;
	logic signed [AW-1:0] read_value_q;
	logic            sat_q;

	logic [EXT_W-1:0]  head_src_ext;
	logic [EXT_W-1:0]  head_tgt_ext;
	logic [EXT_W-1:0]  cur_tgt_ext;
	logic [ADDR_W-1:0] head_src_addr;
	logic [ADDR_W-1:0] head_tgt_addr;
	logic [ADDR_W-1:0] cur_tgt_addr;
	logic              sweep;
	logic              sweep_last;
	logic              coef_we;
	logic              coef_re;
	logic              res_re;
	logic              res_we;
	logic [ADDR_W-1:0] res_wa;
	logic [AW:0]       res_wd;
	logic              delta_valid;
	logic signed [ssga_pkg::DELTA_W-1:0] delta;
	logic signed [UPD_W-1:0] upd;
	logic signed [AW-1:0]    new_acc;
	logic              ovf;

	assign head_src_ext  = EXT_W'(head_item.src);
	assign head_tgt_ext  = EXT_W'(head_item.tgt);
	assign cur_tgt_ext   = EXT_W'(cur_q.tgt);
	assign head_src_addr = head_src_ext[ADDR_W-1:0];
	assign head_tgt_addr = head_tgt_ext[ADDR_W-1:0];
	assign cur_tgt_addr  = cur_tgt_ext[ADDR_W-1:0];

	assign pop     = (state_q == ST_IDLE) & head_valid;
	assign coef_we = pop & (head_item.op == ssga_pkg::OP_LOAD);
	assign coef_re = pop & (head_item.op == ssga_pkg::OP_ACC);
	assign res_re  = pop & ((head_item.op == ssga_pkg::OP_ACC) |
	                        (head_item.op == ssga_pkg::OP_READ));

	assign sweep      = (state_q == ST_INIT) | (state_q == ST_CLEAR);
	assign sweep_last = cnt_q == ADDR_W'(GRID_POINTS - 1);
	assign init_busy  = state_q == ST_INIT;

	ssga_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (state_q == ST_MUL),
		.weights     (cur_q.words),
		.coefs       (coef_rd_q),
		.delta_valid (delta_valid),
		.delta       (delta)
	);

	// Saturating accumulator update.
	assign upd = UPD_W'($signed(res_rd_q[AW-1:0])) + UPD_W'(delta);

	always_comb begin
		if (upd > ACC_HI) begin
			new_acc = ACC_HI[AW-1:0];
			ovf     = 1'b1;
		end else if (upd < ACC_LO) begin
			new_acc = ACC_LO[AW-1:0];
			ovf     = 1'b1;
		end else begin
			new_acc = upd[AW-1:0];
			ovf     = 1'b0;
		end
	end

	assign res_we = sweep | ((state_q == ST_WAIT) & delta_valid);
	assign res_wa = sweep ? cnt_q : cur_tgt_addr;
	assign res_wd = sweep ? '0 : {res_rd_q[AW] | ovf, new_acc};

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[head_src_addr] <= head_item.words;
		end
		if (coef_re) begin
			coef_rd_q <= coef_mem[head_src_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_wa] <= res_wd;
		end
		if (res_re) begin
			res_rd_q <= res_mem[head_tgt_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_item;
		end
		if (state_q == ST_READ) begin
			read_value_q <= cur_q.read_ok ? $signed(res_rd_q[AW-1:0]) : '0;
			sat_q        <= cur_q.read_ok & res_rd_q[AW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= state_q == ST_READ;
			case (state_q)
				ST_INIT, ST_CLEAR: begin
					if (sweep_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						case (head_item.op)
							ssga_pkg::OP_CLEAR: state_q <= ST_CLEAR;
							ssga_pkg::OP_READ:  state_q <= ST_READ;
							ssga_pkg::OP_ACC:   state_q <= ST_MUL;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: state_q <= ST_IDLE;
				ST_MUL:  state_q <= ST_WAIT;
				ST_WAIT: begin
					if (delta_valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done           = done_q;
	assign read_value     = read_value_q;
	assign saturated_flag = sat_q;

endmodule

// ===== rtl/sparse_gyroaverage_accumulate.sv =====
// Top level of the sparse scatter-accumulate engine.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// request   in         start high, busy low          req_type, source_index, target_index,
//                                                    word_0 .. word_3
// result    out        done high for one cycle       read_value, saturated_flag
//
// Sequence: a load writes the coefficient memory when it leaves the queue; a read
// registers its result, shown with done; an accumulate runs coefficient/accumulator
// read, multiply, two add stages with the rounding and write-back; a clear sweeps
// one result-memory row per cycle. Reset: after arst_n the back end sweeps the
// whole result memory, holding busy high; coefficient memory is not cleared.
// Stalls: busy rises only when the two-entry request queue is full or during the
// reset sweep; the receiver cannot stall, results are never held back.

module sparse_gyroaverage_accumulate #(
	parameter int GRID_POINTS = ssga_pkg::GRID_POINTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         req_type,
	input  logic [ssga_pkg::IDX_W-1:0]         source_index,
	input  logic [ssga_pkg::IDX_W-1:0]         target_index,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_0,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_1,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_2,
	input  logic signed [ssga_pkg::WORD_W-1:0] word_3,
	output logic                               done,
	output logic signed [ssga_pkg::ACC_W-1:0]  read_value,
	output logic                               saturated_flag
);

	// Front to queue.
	logic            push;
	ssga_pkg::item_t push_item;
	logic            q_full;

	// Queue to back end.
	logic            head_valid;
	ssga_pkg::item_t head_item;
	logic            pop;
	logic            init_busy;

	// Classify the item and drop loads/accumulates that fall outside the grid.
	ssga_front #(
		.GRID_POINTS (GRID_POINTS)
	) u_front (
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.source_index (source_index),
		.target_index (target_index),
		.word_0       (word_0),
		.word_1       (word_1),
		.word_2       (word_2),
		.word_3       (word_3),
		.q_full       (q_full),
		.init_busy    (init_busy),
		.push         (push),
		.push_item    (push_item)
	);

	// Hold items while the back end works on a long accumulate or clear.
	ssga_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Execute items in order, one at a time; this keeps read-modify-write
	// updates of one accumulator ordered without any forwarding.
	ssga_back #(
		.GRID_POINTS (GRID_POINTS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.init_busy      (init_busy),
		.done           (done),
		.read_value     (read_value),
		.saturated_flag (saturated_flag)
	);

endmodule
